// File: src/slis_pkg.sv
// ----------------------------------------------------------------------------
// slis_pkg
// Shared types and constants for the sorted insertion list: status codes,
// datapath control word and sequencer condition flags.
// ----------------------------------------------------------------------------
package slis_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W       = 32;
	localparam int ST_W         = 3;

	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY     = 3'd2;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [ST_W-1:0] ST_KEY_LAST  = 3'd4;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_CNT,
		PTR_ZERO,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_SHIFT,
		WR_KEY
	} wr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_CUT
	} cnt_op_t;

	// one microinstruction's datapath fields
	typedef struct packed {
		ptr_op_t         ptr_op;
		logic            ra_m1;    // read address is next pointer minus one
		wr_op_t          wr_op;
		logic            emit;
		logic [ST_W-1:0] st;
		logic            item_rd;  // item from read data, else zero
		logic            last_end; // last flag from end test, else one
		cnt_op_t         cnt_op;
		logic            pos_ld;
	} ctrl_t;

	// datapath tests seen by the sequencer
	typedef struct packed {
		logic full;
		logic cnt0;
		logic ngt;
		logic ptr1;
		logic eq;
		logic at_end;
		logic ptr_cnt;
	} flags_t;

endpackage

// File: src/slis_mem.sv
// ----------------------------------------------------------------------------
// slis_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module slis_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata_q
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

// File: src/slis_seq.sv
// ----------------------------------------------------------------------------
// slis_seq
// Microcode sequencer: step counter, control store and two-way conditional
// jumps. Emit steps hold while the output register is occupied.
// ----------------------------------------------------------------------------
module slis_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             action,
	input  slis_pkg::flags_t flags,
	input  logic             out_hold,
	output slis_pkg::ctrl_t  ctrl,
	output logic             go,
	output logic             idle
);

	import slis_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_CHK,
		S_INS_CMP,
		S_INS_PUT,
		S_INS_OK,
		S_EM_FULL,
		S_SPL_CHK,
		S_SPL_SRCH,
		S_SPL_FOUND,
		S_SPL_EMIT,
		S_SPL_CUT,
		S_EM_EMPTY,
		S_EM_NF,
		S_EM_KL
	} step_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_FULL,
		C_CNT0,
		C_NGT,
		C_PTR1,
		C_EQ,
		C_END,
		C_PEND
	} cond_t;

	typedef struct packed {
		cond_t ca;
		step_t ta;
		cond_t cb;
		step_t tb;
		step_t tn;
		ctrl_t c;
	} uop_t;

	function automatic uop_t rom(step_t s);
		uop_t u;
		u = '0;
		unique case (s)
			S_IDLE: begin
				u.tn = S_IDLE;
			end
			S_INS_CHK: begin
				u.ca = C_FULL;  u.ta = S_EM_FULL;
				u.cb = C_CNT0;  u.tb = S_INS_PUT;
				u.tn = S_INS_CMP;
				u.c.ptr_op = PTR_CNT;
				u.c.ra_m1  = 1'b1;
			end
			S_INS_CMP: begin
				u.ca = C_NGT;   u.ta = S_INS_OK;
				u.cb = C_PTR1;  u.tb = S_INS_PUT;
				u.tn = S_INS_CMP;
				u.c.ptr_op = PTR_DEC;
				u.c.ra_m1  = 1'b1;
				u.c.wr_op  = WR_SHIFT;
			end
			S_INS_PUT: begin
				u.tn = S_INS_OK;
				u.c.wr_op = WR_KEY;
			end
			S_INS_OK: begin
				u.tn = S_IDLE;
				u.c.emit   = 1'b1;
				u.c.st     = ST_OK;
				u.c.cnt_op = CNT_INC;
			end
			S_EM_FULL: begin
				u.tn = S_IDLE;
				u.c.emit = 1'b1;
				u.c.st   = ST_FULL;
			end
			S_SPL_CHK: begin
				u.ca = C_CNT0;  u.ta = S_EM_EMPTY;
				u.tn = S_SPL_SRCH;
				u.c.ptr_op = PTR_ZERO;
			end
			S_SPL_SRCH: begin
				u.ca = C_EQ;    u.ta = S_SPL_FOUND;
				u.cb = C_END;   u.tb = S_EM_NF;
				u.tn = S_SPL_SRCH;
				u.c.ptr_op = PTR_INC;
				u.c.pos_ld = 1'b1;
			end
			S_SPL_FOUND: begin
				u.ca = C_PEND;  u.ta = S_EM_KL;
				u.tn = S_SPL_EMIT;
			end
			S_SPL_EMIT: begin
				u.ca = C_END;   u.ta = S_SPL_CUT;
				u.tn = S_SPL_EMIT;
				u.c.ptr_op   = PTR_INC;
				u.c.emit     = 1'b1;
				u.c.st       = ST_OK;
				u.c.item_rd  = 1'b1;
				u.c.last_end = 1'b1;
			end
			S_SPL_CUT: begin
				u.tn = S_IDLE;
				u.c.cnt_op = CNT_CUT;
			end
			S_EM_EMPTY: begin
				u.tn = S_IDLE;
				u.c.emit = 1'b1;
				u.c.st   = ST_EMPTY;
			end
			S_EM_NF: begin
				u.tn = S_IDLE;
				u.c.emit = 1'b1;
				u.c.st   = ST_NOT_FOUND;
			end
			S_EM_KL: begin
				u.tn = S_IDLE;
				u.c.emit = 1'b1;
				u.c.st   = ST_KEY_LAST;
			end
			default: begin
				u.tn = S_IDLE;
			end
		endcase
		return u;
	endfunction

	function automatic logic test(cond_t c, flags_t f);
		logic r;
		unique case (c)
			C_NEVER: r = 1'b0;
			C_FULL:  r = f.full;
			C_CNT0:  r = f.cnt0;
			C_NGT:   r = f.ngt;
			C_PTR1:  r = f.ptr1;
			C_EQ:    r = f.eq;
			C_END:   r = f.at_end;
			C_PEND:  r = f.ptr_cnt;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	step_t upc_q;
	step_t upc_d;
	uop_t  uop;
	logic  stall;

	assign uop   = rom(upc_q);
	assign ctrl  = uop.c;
	assign idle  = (upc_q == S_IDLE);
	assign stall = uop.c.emit && out_hold;
	assign go    = !idle && !stall;

	always_comb begin
		if (idle) begin
			if (in_valid) begin
				upc_d = action ? S_SPL_CHK : S_INS_CHK;
			end else begin
				upc_d = S_IDLE;
			end
		end else if (stall) begin
			upc_d = upc_q;
		end else if (test(uop.ca, flags)) begin
			upc_d = uop.ta;
		end else if (test(uop.cb, flags)) begin
			upc_d = uop.tb;
		end else begin
			upc_d = uop.tn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

// File: src/sorted_list_insert_split.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_split
// Sorted store of up to CAPACITY signed words with insert and split-after-key.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, action, value): action 0 inserts value at
// its sorted place, action 1 splits the list after the first entry equal to
// value. One transaction is taken at a time; in_ready is high only while the
// sequencer waits at its idle step.
// Output channel (out_valid/out_ready, status, item, last): insert gives one
// result (ok or full). Split gives one error result (empty, not_found,
// key_last) or the removed tail, one result per entry in ascending order,
// last set on the final one.
// Sequencer steps from acceptance: insert checks the count, moves up one
// entry per step to the key's place, writes the key and reports ok, or
// reports full. Split checks the count, scans one entry per step, checks a
// found key for the last entry, emits one result per step and cuts the count
// after a tail. A result is registered at the end of its step; the sequencer
// passes its idle step before the next transaction is taken. The single read
// port of the entry memory sets one entry per cycle unless an emit step stalls.
// The output register holds a result until taken; an emit step waits while
// it is occupied, so a stalled receiver stalls the sequencer, nothing lost.
// Reset empties the list at once (count to zero); entries need no clearing.
// ----------------------------------------------------------------------------
module sorted_list_insert_split #(
	parameter int CAPACITY = slis_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic signed [slis_pkg::DATA_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic        [slis_pkg::ST_W-1:0]    status,
	output logic signed [slis_pkg::DATA_W-1:0]  item,
	output logic                                last
);

	import slis_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	ctrl_t              ctrl;
	flags_t             flags;
	logic               go;
	logic               idle;
	logic               out_hold;

	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      ptr_q;
	logic [CW-1:0]      ptr_d;
	logic [CW-1:0]      pos_q;
	logic [CW-1:0]      ptr_p1;
	logic [CW-1:0]      ra_full;
	logic [DATA_W-1:0]  key_q;
	logic [DATA_W-1:0]  rdata;
	logic               gt;
	logic               mem_we;
	logic [DATA_W-1:0]  mem_wdata;

	logic               out_valid_q;
	logic [ST_W-1:0]    status_q;
	logic [DATA_W-1:0]  item_q;
	logic               last_q;

	assign in_ready  = idle;
	assign out_hold  = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign item      = item_q;
	assign last      = last_q;

	slis_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.flags    (flags),
		.out_hold (out_hold),
		.ctrl     (ctrl),
		.go       (go),
		.idle     (idle)
	);

	assign ptr_p1 = CW'(ptr_q + CW'(1));
	assign gt     = $signed(rdata) > $signed(key_q);

	always_comb begin
		flags.full    = (cnt_q == CW'(CAPACITY));
		flags.cnt0    = (cnt_q == '0);
		flags.ngt     = !gt;
		flags.ptr1    = (ptr_q == CW'(1));
		flags.eq      = (rdata == key_q);
		flags.at_end  = (ptr_p1 == cnt_q);
		flags.ptr_cnt = (ptr_q == cnt_q);
	end

	always_comb begin
		ptr_d = ptr_q;
		if (go) begin
			case (ctrl.ptr_op)
				PTR_HOLD: ptr_d = ptr_q;
				PTR_CNT:  ptr_d = cnt_q;
				PTR_ZERO: ptr_d = '0;
				PTR_INC:  ptr_d = ptr_p1;
				PTR_DEC:  ptr_d = CW'(ptr_q - CW'(1));
				default:  ptr_d = ptr_q;
			endcase
		end
	end

	// read ahead at the pointer's next value so data lines up with the step
	assign ra_full = ctrl.ra_m1 ? CW'(ptr_d - CW'(1)) : ptr_d;

	assign mem_we    = go && (ctrl.wr_op != WR_NONE);
	assign mem_wdata = (ctrl.wr_op == WR_SHIFT && gt) ? rdata : key_q;

	slis_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.DW    (DATA_W)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (ptr_q[AW-1:0]),
		.wdata   (mem_wdata),
		.raddr   (ra_full[AW-1:0]),
		.rdata_q (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ptr_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ptr_q <= ptr_d;
			if (go && ctrl.pos_ld) begin
				pos_q <= ptr_q;
			end
			if (go) begin
				case (ctrl.cnt_op)
					CNT_HOLD: cnt_q <= cnt_q;
					CNT_INC:  cnt_q <= CW'(cnt_q + CW'(1));
					CNT_CUT:  cnt_q <= CW'(pos_q + CW'(1));
					default:  cnt_q <= cnt_q;
				endcase
			end
			if (go && ctrl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && idle) begin
			key_q <= value;
		end
		if (go && ctrl.emit) begin
			status_q <= ctrl.st;
			item_q   <= ctrl.item_rd ? rdata : '0;
			last_q   <= ctrl.last_end ? flags.at_end : 1'b1;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		idle |-> !mem_we)
		else $error("entry write while idle");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transaction taken while busy");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (last && item == '0))
		else $error("error result not single or item not zero");

	a_count_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q) && status == ST_OK && !$past(idle)
		 && $past(ctrl.cnt_op) == CNT_INC) |-> (cnt_q == CW'($past(cnt_q) + CW'(1))))
		else $error("insert result without count update");

endmodule

// File: tb/tb_sorted_list_insert_split.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_split
// Drives insert and split transactions into the sorted list and checks every
// result against a behavioral copy of the list kept inside the bench. A short
// directed run covers empty, full, absent key, key at the end, duplicates and
// the smallest key; a random run then builds lists of random sizes and splits
// them mostly on stored keys, with random idle and stall cycles on both sides.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_split;
	import slis_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam int CNT_W = $clog2(CAP + 1);
	localparam int N_RANDOM = 470;
	localparam int QUIET_LIMIT = 2000;
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_SPLIT = 1'b1;
	localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VMAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic [CAP-1:0][DATA_W-1:0] ent;
		logic [CNT_W-1:0]           used;
	} list_t;

	typedef struct packed {
		logic [ST_W-1:0]          status;
		logic signed [DATA_W-1:0] item;
		logic                     last;
	} res_t;

	typedef struct {
		logic                     act;
		logic signed [DATA_W-1:0] val;
		bit                       drain;
	} op_t;

	logic clk = 1'b1;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = ACT_INSERT;
	logic signed [DATA_W-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ST_W-1:0] status;
	logic signed [DATA_W-1:0] item;
	logic last;

	op_t pending[$];
	res_t expq[$];
	list_t plan;
	list_t model;
	res_t step_out [CAP];
	int step_n;
	res_t got, want;
	int n_in, n_exp, n_seen, errors, quiet;
	int n_placed, n_full, n_empty, n_absent, n_keylast, n_cut, n_tail;
	logic calm;

	sorted_list_insert_split #(.CAPACITY(CAP)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.item(item),
		.last(last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	assign calm = (n_in >= 200 && n_in < 280);

	function automatic res_t mk_res(logic [ST_W-1:0] st, logic signed [DATA_W-1:0] it,
			logic lst);
		res_t r;
		r.status = st;
		r.item = it;
		r.last = lst;
		return r;
	endfunction

	// apply one transaction to a list, return the number of results
	function automatic int list_step(inout list_t s, input logic act,
			input logic signed [DATA_W-1:0] v, output res_t r [CAP]);
		int n, pos, hit, i, k;
		n = s.used;
		k = 0;
		hit = -1;
		for (i = 0; i < CAP; i++)
			r[i] = '0;
		if (act == ACT_INSERT) begin
			if (n >= CAP) begin
				r[0] = mk_res(ST_FULL, '0, 1'b1);
				return 1;
			end
			pos = 0;
			while (pos < n && $signed(s.ent[pos]) < v)
				pos++;
			for (i = n; i > pos; i--)
				s.ent[i] = s.ent[i-1];
			s.ent[pos] = v;
			s.used = CNT_W'(n + 1);
			r[0] = mk_res(ST_OK, '0, 1'b1);
			return 1;
		end
		if (n == 0) begin
			r[0] = mk_res(ST_EMPTY, '0, 1'b1);
			return 1;
		end
		for (i = 0; i < n; i++)
			if (hit < 0 && $signed(s.ent[i]) == v)
				hit = i;
		if (hit < 0) begin
			r[0] = mk_res(ST_NOT_FOUND, '0, 1'b1);
			return 1;
		end
		if (hit + 1 == n) begin
			r[0] = mk_res(ST_KEY_LAST, '0, 1'b1);
			return 1;
		end
		for (i = hit + 1; i < n; i++) begin
			r[k] = mk_res(ST_OK, s.ent[i], i + 1 == n);
			k++;
		end
		s.used = CNT_W'(hit + 1);
		return k;
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_val();
		case ($urandom_range(0, 3))
			0: return $signed($urandom_range(0, 15)) - 8;
			1: return $urandom_range(0, 1) ? VMIN + $urandom_range(0, 3)
				: VMAX - $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_op(logic act, logic signed [DATA_W-1:0] v, bit drain);
		res_t scratch [CAP];
		op_t o;
		void'(list_step(plan, act, v, scratch));
		o.act = act;
		o.val = v;
		o.drain = drain;
		pending.push_back(o);
	endtask

	task automatic note_mismatch(string msg);
		errors++;
		if (errors <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// driver: presents pending transactions, predicts results on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_INSERT;
			value <= '0;
			n_in <= 0;
			n_exp <= 0;
		end else begin
			if (in_valid && in_ready) begin
				step_n = list_step(model, action, value, step_out);
				for (int i = 0; i < step_n; i++)
					expq.push_back(step_out[i]);
				n_in <= n_in + 1;
				n_exp <= n_exp + step_n;
				case (step_out[0].status)
					ST_FULL: n_full++;
					ST_EMPTY: n_empty++;
					ST_NOT_FOUND: n_absent++;
					ST_KEY_LAST: n_keylast++;
					default: begin
						if (action == ACT_INSERT) begin
							n_placed++;
						end else begin
							n_cut++;
							n_tail += step_n;
						end
					end
				endcase
			end
			if (!in_valid || in_ready) begin
				if (pending.size() != 0
						&& (!pending[0].drain || (!in_valid && n_exp == n_seen))
						&& (calm || $urandom_range(0, 99) >= 29)) begin
					in_valid <= 1'b1;
					action <= pending[0].act;
					value <= pending[0].val;
					void'(pending.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compares each result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			n_seen <= 0;
		end else begin
			if (out_valid && out_ready) begin
				n_seen <= n_seen + 1;
				got = mk_res(status, item, last);
				if (expq.size() == 0) begin
					note_mismatch($sformatf("unexpected result status %0d item %0d last %0b",
						got.status, got.item, got.last));
				end else begin
					want = expq.pop_front();
					if (got.status !== want.status || got.item !== want.item
							|| got.last !== want.last)
						note_mismatch($sformatf(
							"expected status %0d item %0d last %0b, got %0d %0d %0b",
							want.status, want.item, want.last,
							got.status, got.item, got.last));
				end
			end
			out_ready <= calm || $urandom_range(0, 99) >= 29;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
				$display("sorted_list_insert_split: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int target;
		logic signed [DATA_W-1:0] v;
		plan = '0;
		model = '0;
		errors = 0;
		quiet = 0;
		n_placed = 0;
		n_full = 0;
		n_empty = 0;
		n_absent = 0;
		n_keylast = 0;
		n_cut = 0;
		n_tail = 0;

		// directed
		add_op(ACT_SPLIT, 5, 0);
		add_op(ACT_INSERT, VMIN, 0);
		add_op(ACT_INSERT, VMAX, 0);
		add_op(ACT_INSERT, 0, 0);
		add_op(ACT_INSERT, -1, 0);
		add_op(ACT_INSERT, 1, 0);
		add_op(ACT_INSERT, 7, 0);
		add_op(ACT_INSERT, 7, 0);
		add_op(ACT_INSERT, 7, 0);
		add_op(ACT_INSERT, 32'sh4000_0000, 0);
		add_op(ACT_INSERT, 32'shc000_0000, 0);
		add_op(ACT_INSERT, 100, 0);
		add_op(ACT_INSERT, -100, 0);
		add_op(ACT_INSERT, VMAX - 1, 0);
		add_op(ACT_INSERT, VMIN + 1, 0);
		add_op(ACT_INSERT, 42, 0);
		add_op(ACT_INSERT, 3, 0);
		add_op(ACT_INSERT, 9, 0);
		add_op(ACT_SPLIT, 8, 0);
		add_op(ACT_SPLIT, VMAX, 0);
		add_op(ACT_SPLIT, 7, 1);
		add_op(ACT_SPLIT, VMIN, 0);
		add_op(ACT_SPLIT, VMIN, 0);

		// random: fill to a random size, then split mostly on stored keys
		add_op(ACT_INSERT, rand_val(), 1);
		while (pending.size() < 23 + N_RANDOM) begin
			target = ($urandom_range(0, 5) == 0) ? CAP : $urandom_range(1, CAP);
			while (plan.used < target)
				add_op(ACT_INSERT, rand_val(), $urandom_range(0, 39) == 0);
			if (plan.used == CAP && $urandom_range(0, 1))
				add_op(ACT_INSERT, rand_val(), 0);
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 9) < 7)
					v = plan.ent[$urandom_range(0, plan.used - 1)];
				else
					v = rand_val();
				add_op(ACT_SPLIT, v, $urandom_range(0, 39) == 0);
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || in_valid || n_seen != n_exp)
			@(negedge clk);
		repeat (40) @(posedge clk);
		if (expq.size() != 0)
			note_mismatch($sformatf("%0d expected results never arrived", expq.size()));

		$display("covered %0d transactions in, %0d results out; %0d values placed, %0d full",
			n_in, n_seen, n_placed, n_full);
		$display("splits: %0d cut (%0d tail values), %0d empty, %0d absent, %0d on last key",
			n_cut, n_tail, n_empty, n_absent, n_keylast);
		if (errors == 0)
			$display("sorted_list_insert_split: match");
		else
			$display("sorted_list_insert_split: mismatch");
		$finish;
	end

endmodule
